>>> rtl/eihc_pkg.sv
// Shared types, constants and helpers for the Ethernet/IPv4 header classifier.
`default_nettype none
package eihc_pkg;

    localparam int MAX_FRAME = 2048;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_NUM_TCP = 8'd6;
    localparam logic [7:0]  PROTO_NUM_UDP = 8'd17;

    localparam int ETH_HDR = 14;
    localparam int IP_MIN  = 20;
    localparam int TCP_MIN = 20;
    localparam int UDP_HDR = 8;
    // TCP data offset sits 12 bytes into the transport header
    localparam int TCP_DOFF_POS = 12;

    localparam logic [11:0] POS_ETYPE_HI = 12'd12;
    localparam logic [11:0] POS_ETYPE_LO = 12'd13;
    localparam logic [11:0] POS_IHL      = 12'd14;
    localparam logic [11:0] POS_TOTAL_HI = 12'd16;
    localparam logic [11:0] POS_TOTAL_LO = 12'd17;
    localparam logic [11:0] POS_PROTO    = 12'd23;

    localparam logic [11:0] COUNT_MAX = 12'd4095;
    localparam logic [10:0] FIELD_MAX = 11'd2047;

    typedef enum logic [2:0] {
        CLS_DROPPED   = 3'd0,
        CLS_TCP       = 3'd1,
        CLS_UDP       = 3'd2,
        CLS_ARP       = 3'd3,
        CLS_IPV4_OTH  = 3'd4,
        CLS_ETH_OTH   = 3'd5,
        CLS_OVERSIZE  = 3'd6
    } packet_class_t;

    // Frame fields as they stand once the final byte has been taken in
    typedef struct packed {
        logic [12:0] frame_len;
        logic [15:0] ether_kind;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [3:0]  transport_words;
        logic        oversize;
    } frame_info_t;

    typedef struct packed {
        packet_class_t cls;
        logic [10:0]   offset;
        logic [10:0]   length;
        logic [15:0]   ether_kind;
        logic [7:0]    protocol;
    } verdict_t;

    function automatic logic [10:0] sat11(input logic [15:0] v);
        logic [10:0] r;
        if (v > {5'b0, FIELD_MAX})
            r = FIELD_MAX;
        else
            r = v[10:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/eihc_capture.sv
// Per-frame byte counter and header field capture.
`default_nettype none
module eihc_capture (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  xfer,
    input  wire  [7:0]           frame_byte,
    input  wire                  frame_last,
    output eihc_pkg::frame_info_t info
);
    import eihc_pkg::*;

    logic [11:0] byte_count_reg, byte_count_next;
    logic [15:0] ether_kind_reg, ether_kind_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [3:0]  transport_words_reg, transport_words_next;
    logic        oversize_reg, oversize_next;
    logic [11:0] doff_pos;

    always_comb
    begin
        ether_kind_next   = ether_kind_reg;
        header_words_next = header_words_reg;
        total_length_next = total_length_reg;
        protocol_next     = protocol_reg;

        case (byte_count_reg)
            POS_ETYPE_HI: ether_kind_next[15:8]   = frame_byte;
            POS_ETYPE_LO: ether_kind_next[7:0]    = frame_byte;
            POS_IHL:      header_words_next       = frame_byte[3:0];
            POS_TOTAL_HI: total_length_next[15:8] = frame_byte;
            POS_TOTAL_LO: total_length_next[7:0]  = frame_byte;
            POS_PROTO:    protocol_next           = frame_byte;
            default:      ;
        endcase

        // data offset byte lies past the IP header that the IHL just captured
        doff_pos = 12'(ETH_HDR + TCP_DOFF_POS) + {6'b0, header_words_next, 2'b00};
        transport_words_next = transport_words_reg;
        if (header_words_next >= 4'd5 && byte_count_reg == doff_pos)
            transport_words_next = frame_byte[7:4];

        oversize_next = oversize_reg | ({20'b0, byte_count_reg} >= 32'(MAX_FRAME));

        if (byte_count_reg < COUNT_MAX)
            byte_count_next = byte_count_reg + 12'd1;
        else
            byte_count_next = byte_count_reg;

        info.frame_len       = {1'b0, byte_count_reg} + 13'd1;
        info.ether_kind      = ether_kind_next;
        info.header_words    = header_words_next;
        info.total_length    = total_length_next;
        info.protocol        = protocol_next;
        info.transport_words = transport_words_next;
        info.oversize        = oversize_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            ether_kind_reg      <= '0;
            header_words_reg    <= '0;
            total_length_reg    <= '0;
            protocol_reg        <= '0;
            transport_words_reg <= '0;
            oversize_reg        <= 1'b0;
        end
        else if (xfer)
        begin
            if (frame_last)
            begin
                byte_count_reg      <= '0;
                ether_kind_reg      <= '0;
                header_words_reg    <= '0;
                total_length_reg    <= '0;
                protocol_reg        <= '0;
                transport_words_reg <= '0;
                oversize_reg        <= 1'b0;
            end
            else
            begin
                byte_count_reg      <= byte_count_next;
                ether_kind_reg      <= ether_kind_next;
                header_words_reg    <= header_words_next;
                total_length_reg    <= total_length_next;
                protocol_reg        <= protocol_next;
                transport_words_reg <= transport_words_next;
                oversize_reg        <= oversize_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/eihc_verdict.sv
// Frame classification and payload location from the captured header fields.
`default_nettype none
module eihc_verdict (
    input  eihc_pkg::frame_info_t info,
    output eihc_pkg::verdict_t    verdict
);
    import eihc_pkg::*;

    logic [12:0]   pl;
    logic [5:0]    ihl;
    logic [5:0]    th;
    logic [15:0]   seg;
    logic [6:0]    base;
    logic          ip_ok;
    logic          is_ipv4;
    packet_class_t cls;
    logic [15:0]   off_w;
    logic [15:0]   len_w;

    always_comb
    begin
        pl      = info.frame_len - 13'(ETH_HDR);
        ihl     = {info.header_words, 2'b00};
        th      = {info.transport_words, 2'b00};
        seg     = info.total_length - {10'b0, ihl};
        base    = 7'(ETH_HDR) + {1'b0, ihl};
        is_ipv4 = (info.ether_kind == ETH_TYPE_IPV4);
        ip_ok   = (pl >= 13'(IP_MIN)) && (ihl >= 6'(IP_MIN)) && (pl >= {7'b0, ihl})
                  && (info.total_length >= {10'b0, ihl})
                  && (info.total_length <= {3'b0, pl});

        cls   = CLS_DROPPED;
        off_w = '0;
        len_w = '0;

        if (info.oversize)
            cls = CLS_OVERSIZE;
        else if (info.frame_len < 13'(ETH_HDR))
            cls = CLS_DROPPED;
        else if (is_ipv4)
        begin
            if (ip_ok)
            begin
                case (info.protocol)
                    PROTO_NUM_TCP:
                    begin
                        if (seg >= 16'(TCP_MIN) && th >= 6'(TCP_MIN) && {10'b0, th} <= seg)
                        begin
                            cls   = CLS_TCP;
                            off_w = {9'b0, base} + {10'b0, th};
                            len_w = seg - {10'b0, th};
                        end
                    end
                    PROTO_NUM_UDP:
                    begin
                        if (seg >= 16'(UDP_HDR))
                        begin
                            cls   = CLS_UDP;
                            off_w = {9'b0, base} + 16'(UDP_HDR);
                            len_w = seg - 16'(UDP_HDR);
                        end
                    end
                    default:
                    begin
                        cls   = CLS_IPV4_OTH;
                        off_w = {9'b0, base};
                        len_w = seg;
                    end
                endcase
            end
        end
        else if (info.ether_kind == ETH_TYPE_ARP)
        begin
            cls   = CLS_ARP;
            off_w = 16'(ETH_HDR);
            len_w = {3'b0, pl};
        end
        else
            cls = CLS_ETH_OTH;

        verdict.cls        = cls;
        verdict.offset     = sat11(off_w);
        verdict.length     = sat11(len_w);
        verdict.ether_kind = info.ether_kind;
        verdict.protocol   = is_ipv4 ? info.protocol : 8'd0;
    end

endmodule
`default_nettype wire

>>> rtl/eth_ipv4_header_classifier_unit.sv
// Ethernet/IPv4 header classifier: top level with snapshot and result registers.
//
// Input channel (in_valid/in_stall): one received frame byte per transfer, in
// wire order, frame_last high on the final byte. A byte transfers on a rising
// edge with in_valid high and in_stall low; while in_stall stays low, one byte
// per cycle is sustained. Output channel (out_valid/out_stall): one verdict per
// frame, giving the class, payload offset and length, ethertype and IP protocol.
// The header fields as updated by the final byte are held in a snapshot register
// as that byte transfers; the classifier compare and subtract path then lands in
// the result register, which raises out_valid. Throughput is one byte per cycle
// and one verdict per cycle while neither side stalls, set by the field capture
// and the one-stage classifier.
// When the receiver stalls, the result holds and one more verdict waits in the
// snapshot; bytes keep flowing until that snapshot is occupied and cannot move,
// then in_stall goes high.
// Reset (rst_n low, asynchronous) clears the byte counter, captured fields and
// both valid flags, so the next byte is taken as the first byte of a frame.
`default_nettype none
module eth_ipv4_header_classifier_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  frame_byte,
    input  wire         frame_last,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  packet_class,
    output logic [10:0] payload_offset,
    output logic [10:0] payload_length,
    output logic [15:0] ether_kind,
    output logic [7:0]  ip_protocol
);
    import eihc_pkg::*;

    logic        in_xfer;
    logic        out_load;
    frame_info_t info;
    frame_info_t snap_reg;
    logic        snap_valid_reg, snap_valid_next;
    verdict_t    verdict;
    verdict_t    result_reg;
    logic        out_valid_reg, out_valid_next;

    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = snap_valid_reg && !out_load;
    assign in_xfer  = in_valid && !in_stall;

    eihc_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .xfer       (in_xfer),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .info       (info)
    );

    eihc_verdict u_verdict (
        .info    (snap_reg),
        .verdict (verdict)
    );

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (in_xfer && frame_last)
            snap_valid_next = 1'b1;
        else if (out_load)
            snap_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = snap_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && frame_last)
            snap_reg <= info;
        if (out_load && snap_valid_reg)
            result_reg <= verdict;
    end

    assign out_valid      = out_valid_reg;
    assign packet_class   = result_reg.cls;
    assign payload_offset = result_reg.offset;
    assign payload_length = result_reg.length;
    assign ether_kind     = result_reg.ether_kind;
    assign ip_protocol    = result_reg.protocol;

endmodule
`default_nettype wire

>>> tb/sv/tb_eth_ipv4_header_classifier_unit.sv
// Testbench for the Ethernet/IPv4 header classifier: stimulus, prediction and checks.
module tb_eth_ipv4_header_classifier_unit;
    import eihc_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 300;
    localparam int RANDOM_MIN_FRAMES = 8;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  frame_byte = 8'h00;
    logic        frame_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  packet_class;
    logic [10:0] payload_offset;
    logic [10:0] payload_length;
    logic [15:0] ether_kind;
    logic [7:0]  ip_protocol;

    eth_ipv4_header_classifier_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_byte     (frame_byte),
        .frame_last     (frame_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .packet_class   (packet_class),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .ether_kind     (ether_kind),
        .ip_protocol    (ip_protocol)
    );

    // predictor state, one frame at a time
    logic [11:0] rx_count;
    logic [15:0] rx_etype;
    logic [3:0]  rx_ihl;
    logic [15:0] rx_total;
    logic [7:0]  rx_proto;
    logic [3:0]  rx_doff;
    logic        rx_oversize;

    verdict_t    verdict_q[$];
    logic [7:0]  frame_q[$];

    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    int mismatches = 0;
    int verdicts_checked = 0;
    int frames_sent = 0;
    int bytes_sent = 0;
    int class_seen[7];

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_frame_state();
        rx_count    = '0;
        rx_etype    = '0;
        rx_ihl      = '0;
        rx_total    = '0;
        rx_proto    = '0;
        rx_doff     = '0;
        rx_oversize = 1'b0;
    endfunction

    function automatic logic [10:0] clip11(input int v);
        return (v > int'(FIELD_MAX)) ? FIELD_MAX : v[10:0];
    endfunction

    // Update the frame fields with one transferred byte; a final byte yields a verdict.
    function automatic void track_byte(input logic [7:0] b, input logic last);
        int pos, flen, pl, ihl, tot, seg, base, th, off, plen;
        packet_class_t cls;
        verdict_t v;
        pos  = int'(rx_count);
        flen = pos + 1;
        cls  = CLS_DROPPED;
        off  = 0;
        plen = 0;
        if (pos >= MAX_FRAME)
            rx_oversize = 1'b1;
        case (rx_count)
            POS_ETYPE_HI: rx_etype[15:8] = b;
            POS_ETYPE_LO: rx_etype[7:0]  = b;
            POS_IHL:      rx_ihl         = b[3:0];
            POS_TOTAL_HI: rx_total[15:8] = b;
            POS_TOTAL_LO: rx_total[7:0]  = b;
            POS_PROTO:    rx_proto       = b;
            default: ;
        endcase
        if (rx_ihl >= 4'd5 && pos == ETH_HDR + int'(rx_ihl) * 4 + TCP_DOFF_POS)
            rx_doff = b[7:4];
        if (rx_count < COUNT_MAX)
            rx_count = rx_count + 12'd1;
        if (!last)
            return;

        if (rx_oversize) begin
            cls = CLS_OVERSIZE;
        end
        else if (flen < ETH_HDR) begin
            cls = CLS_DROPPED;
        end
        else if (rx_etype == ETH_TYPE_IPV4) begin
            pl  = flen - ETH_HDR;
            ihl = int'(rx_ihl) * 4;
            tot = int'(rx_total);
            if (pl >= IP_MIN && ihl >= IP_MIN && pl >= ihl && tot >= ihl && tot <= pl) begin
                seg  = tot - ihl;
                base = ETH_HDR + ihl;
                if (rx_proto == PROTO_NUM_TCP) begin
                    th = int'(rx_doff) * 4;
                    if (seg >= TCP_MIN && th >= TCP_MIN && th <= seg) begin
                        cls  = CLS_TCP;
                        off  = base + th;
                        plen = seg - th;
                    end
                end
                else if (rx_proto == PROTO_NUM_UDP) begin
                    if (seg >= UDP_HDR) begin
                        cls  = CLS_UDP;
                        off  = base + UDP_HDR;
                        plen = seg - UDP_HDR;
                    end
                end
                else begin
                    cls  = CLS_IPV4_OTH;
                    off  = base;
                    plen = seg;
                end
            end
        end
        else if (rx_etype == ETH_TYPE_ARP) begin
            cls  = CLS_ARP;
            off  = ETH_HDR;
            plen = flen - ETH_HDR;
        end
        else begin
            cls = CLS_ETH_OTH;
        end

        v.cls        = cls;
        v.offset     = clip11(off);
        v.length     = clip11(plen);
        v.ether_kind = rx_etype;
        v.protocol   = (rx_etype == ETH_TYPE_IPV4) ? rx_proto : 8'h00;
        verdict_q.push_back(v);
        clear_frame_state();
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic void put_random(input int n);
        for (int i = 0; i < n; i++)
            frame_q.push_back(rand_byte());
    endfunction

    function automatic void put_eth(input logic [15:0] etype);
        frame_q.delete();
        put_random(12);
        frame_q.push_back(etype[15:8]);
        frame_q.push_back(etype[7:0]);
    endfunction

    function automatic logic [15:0] rand_other_etype();
        logic [15:0] t;
        t = 16'($urandom_range(65535));
        while (t == ETH_TYPE_IPV4 || t == ETH_TYPE_ARP)
            t = 16'($urandom_range(65535));
        return t;
    endfunction

    // IPv4 frame: header of ihl_w words (at least 20 bytes laid down), tlen transport
    // bytes, pad trailing bytes; total length is ihl_w*4 + tlen + tot_delta, floored at 0.
    // doff_w < 0 leaves the data offset nibble random.
    function automatic void build_ip(input logic [7:0] proto, input int ihl_w, input int tlen,
                                     input int doff_w, input int pad, input int tot_delta);
        int hlen, tot;
        logic [15:0] tot16;
        hlen = (ihl_w * 4 < IP_MIN) ? IP_MIN : ihl_w * 4;
        tot  = ihl_w * 4 + tlen + tot_delta;
        if (tot < 0)
            tot = 0;
        tot16 = 16'(tot);
        put_eth(ETH_TYPE_IPV4);
        for (int i = 0; i < hlen; i++) begin
            case (i)
                0: frame_q.push_back({4'h4, 4'(ihl_w)});
                2: frame_q.push_back(tot16[15:8]);
                3: frame_q.push_back(tot16[7:0]);
                9: frame_q.push_back(proto);
                default: frame_q.push_back(rand_byte());
            endcase
        end
        for (int i = 0; i < tlen; i++) begin
            if (i == TCP_DOFF_POS && doff_w >= 0)
                frame_q.push_back({4'(doff_w), 4'($urandom_range(15))});
            else
                frame_q.push_back(rand_byte());
        end
        put_random(pad);
    endfunction

    task automatic send_frame_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        frame_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_frame_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: checks each verdict transfer, then picks the next stall value.
    initial begin
        verdict_t exp_v;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                verdicts_checked++;
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict: cls=%0d off=%0d len=%0d type=%h proto=%h",
                                 packet_class, payload_offset, payload_length, ether_kind,
                                 ip_protocol);
                end
                else begin
                    exp_v = verdict_q.pop_front();
                    if (packet_class <= 3'd6)
                        class_seen[packet_class]++;
                    if (packet_class !== exp_v.cls || payload_offset !== exp_v.offset ||
                        payload_length !== exp_v.length || ether_kind !== exp_v.ether_kind ||
                        ip_protocol !== exp_v.protocol) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("verdict mismatch: exp cls=%0d off=%0d len=%0d type=%h proto=%h",
                                     exp_v.cls, exp_v.offset, exp_v.length, exp_v.ether_kind,
                                     exp_v.protocol);
                            $display("                  got cls=%0d off=%0d len=%0d type=%h proto=%h",
                                     packet_class, payload_offset, payload_length, ether_kind,
                                     ip_protocol);
                        end
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 34);
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic test_short_frames();
        frame_q.delete();
        put_random(1);
        send_frame();
        frame_q.delete();
        put_random(13);
        send_frame();
        put_eth(rand_other_etype());
        send_frame();
        // IPv4 type but no IP bytes at all
        put_eth(ETH_TYPE_IPV4);
        send_frame();
        // IP part one byte short of a minimal header
        put_eth(ETH_TYPE_IPV4);
        frame_q.push_back(8'h45);
        put_random(18);
        send_frame();
    endtask

    task automatic test_arp_and_other();
        put_eth(ETH_TYPE_ARP);
        put_random(28);
        send_frame();
        put_eth(ETH_TYPE_ARP);
        put_random(46);
        send_frame();
        put_eth(rand_other_etype());
        put_random(30);
        send_frame();
        frame_q.delete();
        for (int i = 0; i < 40; i++)
            frame_q.push_back(8'hFF);
        send_frame();
        frame_q.delete();
        for (int i = 0; i < 40; i++)
            frame_q.push_back(8'h00);
        send_frame();
    endtask

    task automatic test_ipv4_classes();
        build_ip(PROTO_NUM_TCP, 5, 30, 5, 6, 0);
        send_frame();
        build_ip(PROTO_NUM_TCP, 15, 60, 15, 0, 0);
        send_frame();
        build_ip(PROTO_NUM_UDP, 5, 8, -1, 10, 0);
        send_frame();
        build_ip(PROTO_NUM_UDP, 6, 26, -1, 0, 0);
        send_frame();
        build_ip(8'd1, 5, 12, -1, 4, 0);
        send_frame();
        build_ip(8'd0, 5, 0, -1, 0, 0);
        send_frame();
        build_ip(8'd255, 7, 9, -1, 2, 0);
        send_frame();
    endtask

    task automatic test_malformed_ipv4();
        build_ip(PROTO_NUM_UDP, 4, 12, -1, 0, 0);
        send_frame();
        // header claims 60 bytes, frame ends well inside it
        build_ip(PROTO_NUM_TCP, 15, 20, 5, 0, 0);
        frame_q = frame_q[0:39];
        send_frame();
        build_ip(8'd1, 6, 10, -1, 0, -14);
        send_frame();
        build_ip(PROTO_NUM_UDP, 5, 10, -1, 3, 5);
        send_frame();
        build_ip(PROTO_NUM_TCP, 5, 30, 4, 0, 0);
        send_frame();
        build_ip(PROTO_NUM_TCP, 5, 24, 15, 0, 0);
        send_frame();
        build_ip(PROTO_NUM_TCP, 5, 16, 5, 8, 0);
        send_frame();
        build_ip(PROTO_NUM_UDP, 5, 7, -1, 6, 0);
        send_frame();
    endtask

    task automatic test_oversize();
        // one byte past the limit: only the final byte lands at the oversize position
        build_ip(PROTO_NUM_UDP, 5, 8, -1, MAX_FRAME + 1 - (ETH_HDR + 28), 0);
        send_frame();
    endtask

    task automatic build_random_frame();
        int k, sel, ihl_w, doff_w, tlen, pad, delta, n;
        logic [7:0] proto;
        k = $urandom_range(99);
        if (k < 62 && k >= 55) begin
            put_eth(rand_other_etype());
            put_random($urandom_range(40));
        end
        else if (k >= 45 && k < 55) begin
            put_eth(ETH_TYPE_ARP);
            put_random($urandom_range(50));
        end
        else if (k < 80) begin
            sel    = $urandom_range(2);
            ihl_w  = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
            doff_w = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
            pad    = ($urandom_range(2) == 0) ? 0 : $urandom_range(10);
            delta  = 0;
            if (sel == 0) begin
                proto = PROTO_NUM_TCP;
                tlen  = doff_w * 4 + $urandom_range(24);
            end
            else if (sel == 1) begin
                proto = PROTO_NUM_UDP;
                tlen  = UDP_HDR + $urandom_range(30);
            end
            else begin
                proto = rand_byte();
                tlen  = $urandom_range(30);
            end
            if (k >= 62) begin
                // mostly broken: one field off, or just no padding
                case ($urandom_range(4))
                    0: ihl_w = $urandom_range(15);
                    1: doff_w = $urandom_range(15);
                    2: delta = int'($urandom_range(60)) - 30;
                    3: tlen = $urandom_range(7);
                    default: pad = 0;
                endcase
            end
            build_ip(proto, ihl_w, tlen, proto == PROTO_NUM_TCP ? doff_w : -1, pad, delta);
            if (k >= 62 && $urandom_range(4) == 0) begin
                n = $urandom_range(1, frame_q.size());
                frame_q = frame_q[0:n-1];
            end
        end
        else begin
            frame_q.delete();
            put_random($urandom_range(1, 64));
            if (frame_q.size() > 14 && $urandom_range(1) == 1) begin
                frame_q[12] = ETH_TYPE_IPV4[15:8];
                frame_q[13] = ETH_TYPE_IPV4[7:0];
                frame_q[14] = 8'h45;
            end
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < 10; i++) begin
            build_random_frame();
            send_frame();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_hold_off();
        hold_req = 1'b1;
        // short frames pile up verdicts faster than bytes
        for (int i = 0; i < 10; i++) begin
            frame_q.delete();
            put_random($urandom_range(1, 3));
            send_frame();
        end
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 3; i++) begin
            build_random_frame();
            send_frame();
        end
        wait_drain();
        for (int i = 0; i < 3; i++) begin
            build_random_frame();
            send_frame();
        end
    endtask

    task automatic test_random_frames();
        int start_bytes, start_frames;
        start_bytes  = bytes_sent;
        start_frames = frames_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES ||
               frames_sent - start_frames < RANDOM_MIN_FRAMES) begin
            build_random_frame();
            send_frame();
        end
    endtask

    initial begin
        clear_frame_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_arp_and_other();
        test_ipv4_classes();
        test_malformed_ipv4();
        test_oversize();
        test_back_to_back();
        test_output_hold_off();
        test_drain_pause();
        test_random_frames();

        in_valid <= 1'b0;
        wait_drain();
        repeat (4) @(posedge clk);

        $display("covered %0d frames (%0d bytes), %0d verdicts checked", frames_sent,
                 bytes_sent, verdicts_checked);
        $display("classes: drop %0d tcp %0d udp %0d arp %0d ip %0d eth %0d over %0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4],
                 class_seen[5], class_seen[6]);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
